>>> rtl/lru_key_tracker_assert.svh
// Assertion macros for the LRU key tracker.
// They expand to concurrent assertions on clk and arst_n, or to nothing in synthesis.
`ifndef LRU_KEY_TRACKER_ASSERT_SVH
`define LRU_KEY_TRACKER_ASSERT_SVH
`ifndef SYNTHESIS
// The consequent holds in the same cycle as the antecedent.
`define LKT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// The consequent holds in the cycle after the antecedent.
`define LKT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LKT_ASSERT_NOW(label, ante, cons, msg)
`define LKT_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

>>> rtl/lkt_pkg.sv
// Shared types for the LRU key tracker.
// No dependencies; used by the request channel interface and the top level.
`default_nettype none
package lkt_pkg;
	typedef enum logic {
		CMD_TOUCH = 1'b0,
		CMD_EVICT = 1'b1
	} cmd_t;
endpackage
`default_nettype wire

>>> rtl/lkt_if.sv
// Valid/ready channel interfaces for the LRU key tracker.
// Depends on lkt_pkg for the command type.
`default_nettype none
interface lkt_req_if import lkt_pkg::*; ();
	logic        valid;
	logic        ready;
	cmd_t        cmd;
	logic [31:0] key;
	modport source (output valid, cmd, key, input ready);
	modport sink (input valid, cmd, key, output ready);
endinterface

interface lkt_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] evicted_key;
	logic        key_valid;
	logic        was_present;
	logic        full_refused;
	modport source (output valid, evicted_key, key_valid, was_present, full_refused,
		input ready);
	modport sink (input valid, evicted_key, key_valid, was_present, full_refused,
		output ready);
endinterface
`default_nettype wire

>>> rtl/lkt_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none
module lkt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

>>> rtl/lru_key_tracker.sv
// LRU key tracker top level: ordered key store in one RAM with a scan/shift sequencer.
// Depends on lkt_pkg, lkt_if, lkt_ram and lru_key_tracker_assert.svh.
//
// Channel  Dir  Payload
// req      in   cmd, key
// rsp      out  evicted_key, key_valid, was_present, full_refused
//
// One item at a time. A touch scans the stored keys one per cycle through the RAM read
// port; on a hit it shifts the later keys down one slot per cycle and writes the key at
// the recent end, and on a miss it appends the key or refuses it when the store is full.
// An evict hits slot 0 and shifts the remaining keys down. The result waits in an output
// register while the next item is taken; a further result holds the sequencer until that
// register drains. Reset clears the count and the sequencer; the RAM holds no reset value.
`default_nettype none
module lru_key_tracker import lkt_pkg::*; #(
	parameter int ENTRIES  = 16,
	parameter int KEY_BITS = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	lkt_req_if.sink  req,
	lkt_rsp_if.source rsp
);
	`include "lru_key_tracker_assert.svh"

	localparam int AW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);
	localparam logic [CW-1:0] FULL = CW'(ENTRIES);
	localparam logic [CW-1:0] ONE  = CW'(1);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SCAN  = 5'b00010,
		ST_SHIFT = 5'b00100,
		ST_TAIL  = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t              state_q;
	cmd_t                cmd_q;
	logic [KEY_BITS-1:0] key_q;
	logic [KEY_BITS-1:0] ev_key_q;
	logic                kvalid_q;
	logic                present_q;
	logic                refused_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       ridx_q;
	logic [CW-1:0]       ridx_s1;
	logic                rv_s1;
	logic                rsp_valid_q;
	logic [31:0]         rsp_key_q;
	logic                rsp_kv_q;
	logic                rsp_wp_q;
	logic                rsp_fr_q;

	logic                rd_en;
	logic [KEY_BITS-1:0] rdata;
	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	logic [KEY_BITS-1:0] wr_data;
	logic [KEY_BITS-1:0] key_in;
	logic                accept;
	logic                hit;
	logic                last;
	logic [CW-1:0]       wr_idx;

	assign key_in  = KEY_BITS'(req.key);
	assign accept  = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign rd_en   = ((state_q == ST_SCAN) || (state_q == ST_SHIFT)) && (ridx_q < count_q);
	assign hit     = rv_s1 && ((cmd_q == CMD_EVICT) || (rdata == key_q));
	assign last    = (ridx_s1 == count_q - ONE);

	// Write port: first key into an empty store, append, shift down, or tail write.
	always_comb begin
		wr_en   = 1'b0;
		wr_idx  = '0;
		wr_data = key_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (req.cmd == CMD_TOUCH) && (count_q == '0)) begin
					wr_en   = 1'b1;
					wr_data = key_in;
				end
			end
			ST_SCAN: begin
				if (rv_s1 && !hit && last && (count_q < FULL)) begin
					wr_en  = 1'b1;
					wr_idx = count_q;
				end
			end
			ST_SHIFT: begin
				if (rv_s1) begin
					wr_en   = 1'b1;
					wr_idx  = ridx_s1 - ONE;
					wr_data = rdata;
				end
			end
			ST_TAIL: begin
				if (cmd_q == CMD_TOUCH) begin
					wr_en  = 1'b1;
					wr_idx = count_q - ONE;
				end
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end
	assign wr_addr = wr_idx[AW-1:0];

	lkt_ram #(
		.WIDTH(KEY_BITS),
		.DEPTH(ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.re   (rd_en),
		.raddr(ridx_q[AW-1:0]),
		.rdata(rdata)
	);

	// Read pipeline tracking.
	always_ff @(posedge clk) begin
		ridx_s1 <= ridx_q;
	end

	// Sequencer and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			ridx_q      <= '0;
			rv_s1       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			rv_s1 <= rd_en;
			if (rd_en) begin
				ridx_q <= ridx_q + ONE;
			end
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cmd_q     <= req.cmd;
						key_q     <= key_in;
						ev_key_q  <= '0;
						kvalid_q  <= 1'b0;
						present_q <= 1'b0;
						refused_q <= 1'b0;
						ridx_q    <= '0;
						if (count_q == '0) begin
							if (req.cmd == CMD_TOUCH) begin
								count_q <= ONE;
							end
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (hit) begin
						ev_key_q  <= rdata;
						kvalid_q  <= (cmd_q == CMD_EVICT);
						present_q <= (cmd_q == CMD_TOUCH);
						rv_s1     <= 1'b0;
						if (last) begin
							state_q <= ST_TAIL;
						end else begin
							ridx_q  <= ridx_s1 + ONE;
							state_q <= ST_SHIFT;
						end
					end else if (rv_s1 && last) begin
						rv_s1 <= 1'b0;
						if (count_q < FULL) begin
							count_q <= count_q + ONE;
						end else begin
							refused_q <= 1'b1;
						end
						state_q <= ST_DONE;
					end
				end
				ST_SHIFT: begin
					if (rv_s1 && last) begin
						rv_s1   <= 1'b0;
						state_q <= ST_TAIL;
					end
				end
				ST_TAIL: begin
					if (cmd_q == CMD_EVICT) begin
						count_q <= count_q - ONE;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result payload, loaded when the sequencer hands over an item.
	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && (!rsp_valid_q || rsp.ready)) begin
			rsp_key_q <= kvalid_q ? 32'(ev_key_q) : 32'd0;
			rsp_kv_q  <= kvalid_q;
			rsp_wp_q  <= present_q;
			rsp_fr_q  <= refused_q;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.evicted_key  = rsp_key_q;
	assign rsp.key_valid    = rsp_kv_q;
	assign rsp.was_present  = rsp_wp_q;
	assign rsp.full_refused = rsp_fr_q;

	`LKT_ASSERT_NOW(a_count_max, 1'b1, count_q <= FULL, "key count above capacity")
	`LKT_ASSERT_NEXT(a_accept_busy, accept, state_q != ST_IDLE, "accepted item left no work")
	`LKT_ASSERT_NOW(a_no_rw_clash, wr_en && rd_en, wr_addr != ridx_q[AW-1:0],
		"read and write hit the same slot")
	`LKT_ASSERT_NOW(a_rsp_excl, rsp_valid_q, !(rsp_kv_q && (rsp_wp_q || rsp_fr_q)),
		"evict and touch flags both set")
endmodule
`default_nettype wire

>>> bench/lkt_test_if.sv
// Note: the channel interfaces come from rtl/lkt_if.sv; this file only holds the
// bench-side helpers. It depends on lkt_pkg.
`timescale 1ns / 1ps
package lkt_test_pkg;
	import lkt_pkg::*;

	// Expected result of one item.
	typedef struct {
		logic [31:0] evicted_key;
		logic        key_valid;
		logic        was_present;
		logic        full_refused;
	} lru_result_t;

	// Mirrors the recency order and queues the result each accepted item should give.
	class lru_order_board;
		logic [31:0] recency[$];
		lru_result_t pending[$];
		int          capacity;
		int          errors;
		int          touches;
		int          evicts;
		int          refusals;

		function new(int cap);
			capacity = cap;
			errors = 0;
			touches = 0;
			evicts = 0;
			refusals = 0;
		endfunction

		// Update the recency order for an accepted item and queue its result.
		function void note_item(cmd_t cmd, logic [31:0] key);
			lru_result_t r;
			int          pos;
			r = '{default: 0};
			pos = -1;
			if (cmd == CMD_TOUCH) begin
				touches++;
				foreach (recency[i]) begin
					if (pos < 0 && recency[i] == key) begin
						pos = i;
					end
				end
				if (pos >= 0) begin
					recency.delete(pos);
					recency.push_back(key);
					r.was_present = 1'b1;
				end else if (recency.size() < capacity) begin
					recency.push_back(key);
				end else begin
					r.full_refused = 1'b1;
					refusals++;
				end
			end else begin
				evicts++;
				if (recency.size() > 0) begin
					r.evicted_key = recency.pop_front();
					r.key_valid = 1'b1;
				end
			end
			pending.push_back(r);
		endfunction

		// Compare an accepted result with the oldest expectation.
		function void check_result(lru_result_t got);
			lru_result_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result key=%h valid=%b present=%b refused=%b",
					$realtime, got.evicted_key, got.key_valid, got.was_present,
					got.full_refused);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.evicted_key !== want.evicted_key) begin
				$display("%0t: evicted_key expected %h actual %h", $realtime,
					want.evicted_key, got.evicted_key);
				errors++;
			end
			if (got.key_valid !== want.key_valid) begin
				$display("%0t: key_valid expected %b actual %b", $realtime,
					want.key_valid, got.key_valid);
				errors++;
			end
			if (got.was_present !== want.was_present) begin
				$display("%0t: was_present expected %b actual %b", $realtime,
					want.was_present, got.was_present);
				errors++;
			end
			if (got.full_refused !== want.full_refused) begin
				$display("%0t: full_refused expected %b actual %b", $realtime,
					want.full_refused, got.full_refused);
				errors++;
			end
		endfunction
	endclass
endpackage

>>> bench/lru_key_tracker_test.sv
// Testbench top for the LRU key tracker: drives touch and evict items and checks results.
// Depends on lkt_pkg, lkt_if, lkt_test_pkg and the lru_key_tracker RTL.
`timescale 1ns / 1ps
module lru_key_tracker_test;
	import lkt_pkg::*;
	import lkt_test_pkg::*;

	localparam int ENTRIES = 16;
	localparam int RANDOM_ITEMS = 1830;

	logic clk;
	logic arst_n;
	int   send_idle_pct;
	int   take_idle_pct;
	bit   stim_done;

	lkt_req_if req ();
	lkt_rsp_if rsp ();

	lru_order_board board;

	lru_key_tracker #(.ENTRIES(ENTRIES), .KEY_BITS(32)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.sink)
	);

	// Free-running clock, 2 ns period.
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Send one item, with a random gap before it, and wait for its acceptance.
	task automatic send_item(cmd_t cmd, logic [31:0] key);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.cmd <= cmd;
		req.key <= key;
		@(posedge clk);
		while (!req.ready) begin
			@(posedge clk);
		end
		board.note_item(cmd, key);
	endtask

	// Keys come from a small pool most of the time so that hits and refusals occur.
	function automatic logic [31:0] pick_key();
		int sel;
		sel = $urandom_range(99);
		if (sel < 70) begin
			return 32'(($urandom_range(23)) * 32'h0101_0001);
		end else if (sel < 80) begin
			return ($urandom_range(1)) ? 32'hFFFF_FFFF : 32'h0000_0000;
		end
		return $urandom();
	endfunction

	// Stimulus: directed cases, then random phases with changing idle rates.
	initial begin
		int n;
		int evict_pct;
		board = new(ENTRIES);
		stim_done = 1'b0;
		send_idle_pct = 0;
		arst_n = 1'b0;
		req.valid <= 1'b0;
		req.cmd <= CMD_TOUCH;
		req.key <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Evict while empty, extreme keys, fill to capacity, refuse, hit when full.
		send_item(CMD_EVICT, 32'hFFFF_FFFF);
		send_item(CMD_TOUCH, 32'h0000_0000);
		send_item(CMD_TOUCH, 32'hFFFF_FFFF);
		send_item(CMD_TOUCH, 32'h0000_0000);
		for (int i = 0; i < 14; i++) begin
			send_item(CMD_TOUCH, 32'h5555_0000 + i);
		end
		send_item(CMD_TOUCH, 32'hAAAA_AAAA);
		send_item(CMD_TOUCH, 32'hFFFF_FFFF);
		send_item(CMD_TOUCH, 32'h1234_5678);
		send_item(CMD_EVICT, 32'h0);
		send_item(CMD_EVICT, 32'h0);
		send_item(CMD_TOUCH, 32'hAAAA_AAAA);

		// Hold off until every queued result is back.
		req.valid <= 1'b0;
		while (board.pending.size() != 0) begin
			@(posedge clk);
		end

		// Random part in three idle phases; evict bias drifts so depth sweeps.
		n = 0;
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 34 : (ph == 1) ? 46 : 0;
			for (int i = 0; i < RANDOM_ITEMS / 3; i++) begin
				evict_pct = ((n / 60) % 3 == 0) ? 15 : ((n / 60) % 3 == 1) ? 60 : 35;
				if ($urandom_range(99) < evict_pct) begin
					send_item(CMD_EVICT, $urandom());
				end else begin
					send_item(CMD_TOUCH, pick_key());
				end
				n++;
			end
		end
		req.valid <= 1'b0;
		stim_done = 1'b1;
	end

	// Receiver: random stalls, checks every accepted result.
	initial begin
		lru_result_t got;
		take_idle_pct = 46;
		rsp.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp.valid && rsp.ready) begin
				got.evicted_key = rsp.evicted_key;
				got.key_valid = rsp.key_valid;
				got.was_present = rsp.was_present;
				got.full_refused = rsp.full_refused;
				board.check_result(got);
			end
			take_idle_pct = (send_idle_pct == 46) ? 34 : (send_idle_pct == 0 &&
				board.touches > 100) ? 0 : 46;
			rsp.ready <= ($urandom_range(99) >= take_idle_pct);
		end
	end

	// End of run: drain, settle, report.
	initial begin
		wait (stim_done);
		while (board.pending.size() != 0) begin
			@(posedge clk);
		end
		repeat (80) @(posedge clk);
		$display("Ran %0d touches (%0d refused full) and %0d evicts through a %0d-entry list.",
			board.touches, board.refusals, board.evicts, ENTRIES);
		if (board.errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#4_000_000;
		$display("CHECKS FAILED");
		$finish;
	end
endmodule
